// ===== rtl/tlb_pkg.sv =====
`default_nettype none

package tlb_pkg;

    localparam int IDX_W   = 4;
    localparam int PT_W    = 17;
    localparam int OUT_W   = 21;
    localparam int ORDER_W = 2;
    localparam int ADDR_W  = 2;
    localparam int DATA_W  = 32;

    localparam int OUT_MAX = 1048575;
    localparam int OUT_MIN = -1048576;

    localparam logic [ADDR_W-1:0] REG_BASIS_ORDER = 2'd0;

    localparam logic [ORDER_W-1:0] ORDER_LINEAR = 2'd1;
    localparam logic [ORDER_W-1:0] ORDER_QUAD   = 2'd2;

    // local node numbering: vertices, then edge midpoints
    localparam logic [IDX_W-1:0] NODE_V0  = 4'd0;
    localparam logic [IDX_W-1:0] NODE_V1  = 4'd1;
    localparam logic [IDX_W-1:0] NODE_V2  = 4'd2;
    localparam logic [IDX_W-1:0] NODE_V3  = 4'd3;
    localparam logic [IDX_W-1:0] NODE_E01 = 4'd4;
    localparam logic [IDX_W-1:0] NODE_E12 = 4'd5;
    localparam logic [IDX_W-1:0] NODE_E20 = 4'd6;
    localparam logic [IDX_W-1:0] NODE_E03 = 4'd7;
    localparam logic [IDX_W-1:0] NODE_E13 = 4'd8;
    localparam logic [IDX_W-1:0] NODE_E23 = 4'd9;

endpackage

`default_nettype wire

// ===== rtl/tet_lagrange_basis_eval_unit.sv =====
// Evaluates one Lagrange shape function (linear or quadratic order) of the
// reference tetrahedron and its three partial derivatives at a point. One
// beat can enter every cycle while the output is not held back; a result
// passes through four register stages in turn (input capture, operand and
// gradient build, one signed multiply, floor and saturate). Back-pressure on
// the output only holds beats in place; the input side stays ready while any
// stage is empty. The order register is written over the APB-style port at
// offset 0 and should only change while no beats are in flight.
`default_nettype none

module tet_lagrange_basis_eval_unit #(
    parameter int FRAC_BITS = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [tlb_pkg::ADDR_W-1:0]       paddr,
    input  wire  [tlb_pkg::DATA_W-1:0]       pwdata,
    output logic [tlb_pkg::DATA_W-1:0]       prdata,
    output logic                             pready,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire  [tlb_pkg::IDX_W-1:0]        i_basis_index,
    input  wire  [tlb_pkg::PT_W-1:0]         i_point_x,
    input  wire  [tlb_pkg::PT_W-1:0]         i_point_y,
    input  wire  [tlb_pkg::PT_W-1:0]         i_point_z,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic signed [tlb_pkg::OUT_W-1:0] o_basis_value,
    output logic signed [tlb_pkg::OUT_W-1:0] o_grad_x,
    output logic signed [tlb_pkg::OUT_W-1:0] o_grad_y,
    output logic signed [tlb_pkg::OUT_W-1:0] o_grad_z,
    output logic                             o_index_error
);
    import tlb_pkg::*;

    localparam int AW = ((FRAC_BITS > 19) ? FRAC_BITS : 19) + 5;
    localparam int PW = 2 * AW;
    localparam logic signed [AW-1:0] ONE_FX = AW'(1 << FRAC_BITS);
    localparam logic signed [PW-1:0] SAT_HI = PW'(OUT_MAX);
    localparam logic signed [PW-1:0] SAT_LO = PW'(OUT_MIN);

    function automatic logic signed [OUT_W-1:0] sat(input logic signed [PW-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > SAT_HI) begin
            r = OUT_W'(OUT_MAX);
        end else if (v < SAT_LO) begin
            r = OUT_W'(OUT_MIN);
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

    // config register
    logic [ORDER_W-1:0] r_order;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORDER_LINEAR;
        end else if (psel && penable && pwrite && paddr == REG_BASIS_ORDER) begin
            r_order <= pwdata[ORDER_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_BASIS_ORDER) ? DATA_W'(r_order) : '0;

    // stage valids and ready chain
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    assign w_rdy4 = !r_v4 || i_out_ready;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign o_in_ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_in_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // stage 1: capture
    logic [IDX_W-1:0] r_idx1;
    logic [PT_W-1:0]  r_x1, r_y1, r_z1;

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_idx1 <= i_basis_index;
            r_x1   <= i_point_x;
            r_y1   <= i_point_y;
            r_z1   <= i_point_z;
        end
    end

    // stage 2: operands and gradients
    logic signed [AW-1:0] w_x, w_y, w_z, w_s, w_l;
    logic signed [AW-1:0] n_a2, n_b2, w_gx, w_gy, w_gz;
    logic                 n_err2;

    assign w_x = $signed({{(AW-PT_W){1'b0}}, r_x1});
    assign w_y = $signed({{(AW-PT_W){1'b0}}, r_y1});
    assign w_z = $signed({{(AW-PT_W){1'b0}}, r_z1});
    assign w_s = w_x + w_y + w_z;
    assign w_l = ONE_FX - w_s;

    always_comb begin
        n_a2   = '0;
        n_b2   = ONE_FX;
        w_gx   = '0;
        w_gy   = '0;
        w_gz   = '0;
        n_err2 = 1'b0;
        if (r_order == ORDER_QUAD) begin
            case (r_idx1)
                NODE_V0: begin
                    n_a2 = ONE_FX - (w_s <<< 1);
                    n_b2 = w_l;
                    w_gx = (w_s <<< 2) - (ONE_FX <<< 1) - ONE_FX;
                    w_gy = w_gx;
                    w_gz = w_gx;
                end
                NODE_V1: begin
                    n_a2 = (w_x <<< 1) - ONE_FX;
                    n_b2 = w_x;
                    w_gx = (w_x <<< 2) - ONE_FX;
                end
                NODE_V2: begin
                    n_a2 = (w_y <<< 1) - ONE_FX;
                    n_b2 = w_y;
                    w_gy = (w_y <<< 2) - ONE_FX;
                end
                NODE_V3: begin
                    n_a2 = (w_z <<< 1) - ONE_FX;
                    n_b2 = w_z;
                    w_gz = (w_z <<< 2) - ONE_FX;
                end
                NODE_E01: begin
                    n_a2 = w_x <<< 2;
                    n_b2 = w_l;
                    w_gx = (ONE_FX <<< 2) - (w_x <<< 3) - (w_y <<< 2) - (w_z <<< 2);
                    w_gy = -(w_x <<< 2);
                    w_gz = -(w_x <<< 2);
                end
                NODE_E12: begin
                    n_a2 = w_x <<< 2;
                    n_b2 = w_y;
                    w_gx = w_y <<< 2;
                    w_gy = w_x <<< 2;
                end
                NODE_E20: begin
                    n_a2 = w_l <<< 2;
                    n_b2 = w_y;
                    w_gx = -(w_y <<< 2);
                    w_gy = (ONE_FX <<< 2) - (w_y <<< 3) - (w_x <<< 2) - (w_z <<< 2);
                    w_gz = -(w_y <<< 2);
                end
                NODE_E03: begin
                    n_a2 = w_l <<< 2;
                    n_b2 = w_z;
                    w_gx = -(w_z <<< 2);
                    w_gy = -(w_z <<< 2);
                    w_gz = (ONE_FX <<< 2) - (w_z <<< 3) - (w_x <<< 2) - (w_y <<< 2);
                end
                NODE_E13: begin
                    n_a2 = w_x <<< 2;
                    n_b2 = w_z;
                    w_gx = w_z <<< 2;
                    w_gz = w_x <<< 2;
                end
                NODE_E23: begin
                    n_a2 = w_y <<< 2;
                    n_b2 = w_z;
                    w_gy = w_z <<< 2;
                    w_gz = w_y <<< 2;
                end
                default: begin
                    n_err2 = 1'b1;
                end
            endcase
        end else begin
            // linear: value passes through the multiplier times one
            case (r_idx1)
                NODE_V0: begin
                    n_a2 = w_l;
                    w_gx = -ONE_FX;
                    w_gy = -ONE_FX;
                    w_gz = -ONE_FX;
                end
                NODE_V1: begin
                    n_a2 = w_x;
                    w_gx = ONE_FX;
                end
                NODE_V2: begin
                    n_a2 = w_y;
                    w_gy = ONE_FX;
                end
                NODE_V3: begin
                    n_a2 = w_z;
                    w_gz = ONE_FX;
                end
                default: begin
                    n_err2 = 1'b1;
                end
            endcase
        end
    end

    logic signed [AW-1:0]    r_a2, r_b2;
    logic signed [OUT_W-1:0] r_gx2, r_gy2, r_gz2;
    logic                    r_err2;

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_a2   <= n_a2;
            r_b2   <= n_b2;
            r_gx2  <= sat(PW'(w_gx));
            r_gy2  <= sat(PW'(w_gy));
            r_gz2  <= sat(PW'(w_gz));
            r_err2 <= n_err2;
        end
    end

    // stage 3: product
    logic signed [PW-1:0]    r_p3;
    logic signed [OUT_W-1:0] r_gx3, r_gy3, r_gz3;
    logic                    r_err3;

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_p3   <= PW'(r_a2) * PW'(r_b2);
            r_gx3  <= r_gx2;
            r_gy3  <= r_gy2;
            r_gz3  <= r_gz2;
            r_err3 <= r_err2;
        end
    end

    // stage 4: floor to FRAC_BITS, saturate, zero on index error
    logic signed [PW-1:0] w_q;

    assign w_q = r_p3 >>> FRAC_BITS;

    logic signed [OUT_W-1:0] r_val4, r_gx4, r_gy4, r_gz4;
    logic                    r_err4;

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r_val4 <= r_err3 ? '0 : sat(w_q);
            r_gx4  <= r_err3 ? '0 : r_gx3;
            r_gy4  <= r_err3 ? '0 : r_gy3;
            r_gz4  <= r_err3 ? '0 : r_gz3;
            r_err4 <= r_err3;
        end
    end

    assign o_out_valid   = r_v4;
    assign o_basis_value = r_val4;
    assign o_grad_x      = r_gx4;
    assign o_grad_y      = r_gy4;
    assign o_grad_z      = r_gz4;
    assign o_index_error = r_err4;

`ifndef SYNTH
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_index_error |->
            o_basis_value == '0 && o_grad_x == '0 && o_grad_y == '0 && o_grad_z == '0)
        else $error("error beat carries nonzero fields");

    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without output back-pressure");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

    a_no_gap_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v3 && !r_v2 && !r_v1 && !o_out_valid |=> !o_out_valid)
        else $error("output beat from empty pipeline");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_tet_lagrange_basis_eval_unit.sv =====
`timescale 1ns / 100ps

module tb_tet_lagrange_basis_eval_unit;

    import tlb_pkg::*;

    localparam int  FRAC       = 16;
    localparam int  IDLE_PCT   = 29;
    localparam int  HOLD_LEN   = 48;
    localparam int  DRAIN_GAP  = 8;
    localparam int  STALL_LIM  = 2000;
    localparam logic [PT_W-1:0] PT_ONE = 17'h10000;
    localparam logic [PT_W-1:0] PT_MAX = 17'h1FFFF;

    // order codes with no meaning of their own; the block treats them as linear
    localparam logic [ORDER_W-1:0] ORDER_SPARE_0 = 2'd0;
    localparam logic [ORDER_W-1:0] ORDER_SPARE_3 = 2'd3;

    typedef struct packed {
        logic signed [OUT_W-1:0] value;
        logic signed [OUT_W-1:0] gx;
        logic signed [OUT_W-1:0] gy;
        logic signed [OUT_W-1:0] gz;
        logic                    err;
    } shape_res_t;

    class shape_scoreboard;
        logic [ORDER_W-1:0] order;
        shape_res_t         expq[$];
        int                 errors;
        int                 n_checked;
        int                 n_flagged;

        function new();
            order = ORDER_LINEAR;
            errors = 0;
            n_checked = 0;
            n_flagged = 0;
        endfunction

        function logic signed [OUT_W-1:0] clamp(longint v);
            if (v > OUT_MAX) return OUT_W'(OUT_MAX);
            if (v < OUT_MIN) return OUT_W'(OUT_MIN);
            return v[OUT_W-1:0];
        endfunction

        // exact product, floored to FRAC fraction bits
        function longint fx_prod(longint a, longint b);
            longint p;
            p = a * b;
            return p >>> FRAC;
        endfunction

        function shape_res_t eval_shape(logic [IDX_W-1:0] idx,
                                        logic [PT_W-1:0] px, logic [PT_W-1:0] py,
                                        logic [PT_W-1:0] pz);
            longint one, x, y, z, s, l, v, gx, gy, gz;
            bit bad;
            shape_res_t r;
            one = longint'(1) << FRAC;
            x = longint'(px);
            y = longint'(py);
            z = longint'(pz);
            s = x + y + z;
            l = one - s;
            v = 0; gx = 0; gy = 0; gz = 0;
            bad = 1'b0;
            if (order != ORDER_QUAD) begin
                case (idx)
                    NODE_V0: begin v = l; gx = -one; gy = -one; gz = -one; end
                    NODE_V1: begin v = x; gx = one; end
                    NODE_V2: begin v = y; gy = one; end
                    NODE_V3: begin v = z; gz = one; end
                    default: bad = 1'b1;
                endcase
            end else begin
                case (idx)
                    NODE_V0: begin
                        v = fx_prod(one - 2 * s, l);
                        gx = -3 * one + 4 * s; gy = gx; gz = gx;
                    end
                    NODE_V1: begin v = fx_prod(2 * x - one, x); gx = 4 * x - one; end
                    NODE_V2: begin v = fx_prod(2 * y - one, y); gy = 4 * y - one; end
                    NODE_V3: begin v = fx_prod(2 * z - one, z); gz = 4 * z - one; end
                    NODE_E01: begin
                        v = fx_prod(4 * x, l);
                        gx = 4 * one - 8 * x - 4 * y - 4 * z; gy = -4 * x; gz = -4 * x;
                    end
                    NODE_E12: begin v = fx_prod(4 * x, y); gx = 4 * y; gy = 4 * x; end
                    NODE_E20: begin
                        v = fx_prod(4 * l, y);
                        gx = -4 * y; gy = 4 * one - 8 * y - 4 * x - 4 * z; gz = -4 * y;
                    end
                    NODE_E03: begin
                        v = fx_prod(4 * l, z);
                        gx = -4 * z; gy = -4 * z; gz = 4 * one - 8 * z - 4 * x - 4 * y;
                    end
                    NODE_E13: begin v = fx_prod(4 * x, z); gx = 4 * z; gz = 4 * x; end
                    NODE_E23: begin v = fx_prod(4 * y, z); gy = 4 * z; gz = 4 * y; end
                    default: bad = 1'b1;
                endcase
            end
            if (bad) begin
                v = 0; gx = 0; gy = 0; gz = 0;
            end
            r.value = clamp(v);
            r.gx    = clamp(gx);
            r.gy    = clamp(gy);
            r.gz    = clamp(gz);
            r.err   = bad;
            return r;
        endfunction

        function void note_input(logic [IDX_W-1:0] idx, logic [PT_W-1:0] px,
                                 logic [PT_W-1:0] py, logic [PT_W-1:0] pz);
            expq.insert(expq.size(), eval_shape(idx, px, py, pz));
        endfunction

        function void check_result(shape_res_t got);
            shape_res_t want;
            if (expq.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
                return;
            end
            want = expq.pop_front();
            n_checked++;
            if (got.err) n_flagged++;
            if (got.value !== want.value) begin
                $error("basis_value exp %0d act %0d", want.value, got.value);
                errors++;
            end
            if (got.gx !== want.gx) begin
                $error("grad_x exp %0d act %0d", want.gx, got.gx);
                errors++;
            end
            if (got.gy !== want.gy) begin
                $error("grad_y exp %0d act %0d", want.gy, got.gy);
                errors++;
            end
            if (got.gz !== want.gz) begin
                $error("grad_z exp %0d act %0d", want.gz, got.gz);
                errors++;
            end
            if (got.err !== want.err) begin
                $error("index_error exp %0d act %0d", want.err, got.err);
                errors++;
            end
        endfunction

        function int pending();
            return expq.size();
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [ADDR_W-1:0]       paddr = '0;
    logic [DATA_W-1:0]       pwdata = '0;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic [IDX_W-1:0]        i_basis_index = '0;
    logic [PT_W-1:0]         i_point_x = '0;
    logic [PT_W-1:0]         i_point_y = '0;
    logic [PT_W-1:0]         i_point_z = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic signed [OUT_W-1:0] o_basis_value;
    logic signed [OUT_W-1:0] o_grad_x;
    logic signed [OUT_W-1:0] o_grad_y;
    logic signed [OUT_W-1:0] o_grad_z;
    logic                    o_index_error;

    bit in_idle_en  = 1'b1;
    bit out_idle_en = 1'b1;
    bit hold_req    = 1'b0;
    int n_orders    = 1;
    int stall_cnt   = 0;

    shape_scoreboard sb = new();

    tet_lagrange_basis_eval_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_basis_index (i_basis_index),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_point_z     (i_point_z),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_basis_value (o_basis_value),
        .o_grad_x      (o_grad_x),
        .o_grad_y      (o_grad_y),
        .o_grad_z      (o_grad_z),
        .o_index_error (o_index_error)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // result side: random stalls, plus a long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_out_ready <= out_idle_en ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result({o_basis_value, o_grad_x, o_grad_y, o_grad_z, o_index_error});
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= STALL_LIM) begin
                $display("timeout: no beat moved for %0d cycles", STALL_LIM);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic send_beat(input logic [IDX_W-1:0] idx, input logic [PT_W-1:0] px,
                             input logic [PT_W-1:0] py, input logic [PT_W-1:0] pz);
        if (in_idle_en && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < IDLE_PCT);
        end
        i_in_valid    <= 1'b1;
        i_basis_index <= idx;
        i_point_x     <= px;
        i_point_y     <= py;
        i_point_z     <= pz;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(idx, px, py, pz);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    task automatic write_order(input logic [ORDER_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_BASIS_ORDER;
        pwdata  <= DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.order = val;
        n_orders++;
    endtask

    function automatic logic [PT_W-1:0] edge_coord();
        case ($urandom_range(4))
            0: return '0;
            1: return PT_ONE;
            2: return PT_MAX;
            3: return 17'h0FFFF;
            default: return 17'd1;
        endcase
    endfunction

    // mostly points inside the unit tet, some on corners and some anywhere
    task automatic send_random(input int n);
        logic [PT_W-1:0] c[3];
        logic [PT_W-1:0] t;
        logic [IDX_W-1:0] idx;
        int unsigned room;
        int k;
        int mode;
        for (int i = 0; i < n; i++) begin
            mode = $urandom_range(99);
            if (mode < 70) begin
                room = PT_ONE;
                for (k = 0; k < 3; k++) begin
                    c[k] = PT_W'($urandom_range(room));
                    room -= c[k];
                end
                k = $urandom_range(2);
                t = c[0]; c[0] = c[k]; c[k] = t;
            end else if (mode < 85) begin
                for (k = 0; k < 3; k++) c[k] = edge_coord();
            end else begin
                for (k = 0; k < 3; k++) c[k] = PT_W'($urandom_range(PT_MAX));
            end
            if (sb.order == ORDER_QUAD)
                idx = ($urandom_range(99) < 90) ? IDX_W'($urandom_range(9))
                                                : IDX_W'($urandom_range(15, 10));
            else
                idx = ($urandom_range(99) < 85) ? IDX_W'($urandom_range(3))
                                                : IDX_W'($urandom_range(15, 4));
            send_beat(idx, c[0], c[1], c[2]);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // linear order out of reset: corners, far point, bad indexes
        send_beat(NODE_V0, '0, '0, '0);
        send_beat(NODE_V1, PT_ONE, '0, '0);
        send_beat(NODE_V2, '0, PT_ONE, '0);
        send_beat(NODE_V3, '0, '0, PT_ONE);
        send_beat(NODE_V0, PT_MAX, PT_MAX, PT_MAX);
        send_beat(NODE_E01, 17'h4000, 17'h4000, 17'h4000);
        send_beat(4'hF, PT_MAX, PT_MAX, PT_MAX);
        drain();

        write_order(ORDER_QUAD);
        for (int i = 0; i <= NODE_E23; i++)
            send_beat(IDX_W'(i), 17'h4000, 17'h2000, 17'h6000);
        send_beat(NODE_V0, PT_MAX, PT_MAX, PT_MAX);
        send_beat(NODE_E01, PT_MAX, PT_MAX, PT_MAX);
        send_beat(NODE_E12, PT_ONE, PT_ONE, PT_ONE);
        send_beat(4'd10, 17'h8000, 17'h8000, '0);
        send_beat(4'hF, PT_ONE, '0, '0);
        drain();

        // unused order codes fall back to linear
        write_order(ORDER_SPARE_0);
        send_random(80);
        drain();
        write_order(ORDER_SPARE_3);
        send_random(60);
        drain();
        write_order(ORDER_LINEAR);
        send_random(80);
        drain();

        write_order(ORDER_QUAD);
        send_random(150);
        hold_req = 1'b1;
        send_random(80);
        in_idle_en  = 1'b0;
        out_idle_en = 1'b0;
        send_random(150);
        in_idle_en  = 1'b1;
        out_idle_en = 1'b1;
        send_random(100);
        drain();

        $display("checked %0d result beats (%0d index errors) across %0d order settings",
                 sb.n_checked, sb.n_flagged, n_orders);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.pending());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
